/* design/arp_pkg.sv */
// shared types, constants and reply byte table for the arp request responder
package arp_pkg;

  localparam int unsigned ArpLen       = 28;
  localparam int unsigned JobDepthDflt = 2;

  localparam logic [4:0]  LastPos  = 5'(ArpLen);
  localparam logic [4:0]  FinalIdx = 5'(ArpLen - 1);
  localparam logic [7:0]  HwLen    = 8'd6;
  localparam logic [7:0]  ProtoLen = 8'd4;
  localparam logic [15:0] HwType   = 16'h0001;
  localparam logic [15:0] ProtoIp4 = 16'h0800;
  localparam logic [15:0] OpRequest = 16'h0001;
  localparam logic [15:0] OpReply   = 16'h0002;

  typedef enum logic [2:0] {
    CfgOwnMac  = 3'd0,
    CfgOwnIpA  = 3'd1,
    CfgOwnIpB  = 3'd2,
    CfgOwnIpC  = 3'd3,
    CfgOwnIpD  = 3'd4,
    CfgAddrEn  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    KindLearn = 1'b0,
    KindReply = 1'b1
  } out_kind_e;

  typedef struct packed {
    logic        answer;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
  } arp_job_t;

  typedef struct packed {
    logic [47:0]      own_mac;
    logic [3:0][31:0] own_ip;
    logic [3:0]       addr_en;
  } arp_cfg_t;

  // byte q of the reply, big-endian fields
  function automatic logic [7:0] reply_byte_at(logic [4:0] q, logic [47:0] own_mac,
                                               logic [31:0] tip, logic [47:0] smac,
                                               logic [31:0] sip);
    logic [5:0] sh;
    logic [7:0] r;
    sh = '0;
    r  = '0;
    case (q) inside
      5'd0:      r = HwType[15:8];
      5'd1:      r = HwType[7:0];
      5'd2:      r = ProtoIp4[15:8];
      5'd3:      r = ProtoIp4[7:0];
      5'd4:      r = HwLen;
      5'd5:      r = ProtoLen;
      5'd6:      r = OpReply[15:8];
      5'd7:      r = OpReply[7:0];
      [5'd8:5'd13]: begin
        sh = {3'(5'd13 - q), 3'b000};
        r  = 8'(own_mac >> sh);
      end
      [5'd14:5'd17]: begin
        sh = {3'(5'd17 - q), 3'b000};
        r  = 8'(tip >> sh);
      end
      [5'd18:5'd23]: begin
        sh = {3'(5'd23 - q), 3'b000};
        r  = 8'(smac >> sh);
      end
      [5'd24:5'd27]: begin
        sh = {3'(5'd27 - q), 3'b000};
        r  = 8'(sip >> sh);
      end
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/arp_parser.sv */
// front end: header check, field capture and job hand-off per packet
module arp_parser import arp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [7:0] in_byte_i,
  input  logic     in_last_i,
  input  arp_cfg_t cfg_i,
  input  logic     job_full_i,
  output logic     stall_o,
  output logic     job_push_o,
  output arp_job_t job_o
);

  logic [4:0]  idx_q, idx_d;
  logic        hok_q, hok_d;
  logic [15:0] op_q, op_d;
  logic [47:0] smac_q, smac_d;
  logic [31:0] sip_q, sip_d;
  logic [31:0] tip_q, tip_d;
  logic [7:0]  want;
  logic        check;
  logic        own_hit;
  logic [31:0] tip_next;

  assign stall_o  = (idx_q == FinalIdx) && job_full_i;
  assign tip_next = {tip_q[23:0], in_byte_i};

  always_comb begin
    own_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (cfg_i.addr_en[i] && (cfg_i.own_ip[i] == tip_next)) own_hit = 1'b1;
    end
  end

  always_comb begin
    check = 1'b1;
    want  = '0;
    case (idx_q)
      5'd0:    want = HwType[15:8];
      5'd1:    want = HwType[7:0];
      5'd2:    want = ProtoIp4[15:8];
      5'd3:    want = ProtoIp4[7:0];
      5'd4:    want = HwLen;
      5'd5:    want = ProtoLen;
      default: check = 1'b0;
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    hok_d  = hok_q;
    op_d   = op_q;
    smac_d = smac_q;
    sip_d  = sip_q;
    tip_d  = tip_q;
    if (accept_i) begin
      if (idx_q < LastPos) begin
        if (check && (in_byte_i != want)) hok_d = 1'b0;
        case (idx_q) inside
          [5'd6:5'd7]:   op_d   = {op_q[7:0], in_byte_i};
          [5'd8:5'd13]:  smac_d = {smac_q[39:0], in_byte_i};
          [5'd14:5'd17]: sip_d  = {sip_q[23:0], in_byte_i};
          [5'd24:5'd27]: tip_d  = tip_next;
          default:       ;
        endcase
        idx_d = idx_q + 5'd1;
      end
      if (in_last_i) begin
        idx_d = '0;
        hok_d = 1'b1;
      end
    end
  end

  assign job_push_o       = accept_i && (idx_q == FinalIdx) && hok_q;
  assign job_o.answer     = (op_q == OpRequest) && own_hit;
  assign job_o.sender_ip  = sip_q;
  assign job_o.sender_mac = smac_q;
  assign job_o.target_ip  = tip_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hok_q  <= 1'b1;
      op_q   <= '0;
      smac_q <= '0;
      sip_q  <= '0;
      tip_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      hok_q  <= hok_d;
      op_q   <= op_d;
      smac_q <= smac_d;
      sip_q  <= sip_d;
      tip_q  <= tip_d;
    end
  end

endmodule

/* design/arp_job_fifo.sv */
// small register queue of parsed packet jobs
module arp_job_fifo import arp_pkg::*; #(
  parameter int unsigned Depth = JobDepthDflt
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  arp_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output arp_job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  arp_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntMax);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

/* design/arp_reply_gen.sv */
// back end: emits the learn beat and the reply bytes into the output register
module arp_reply_gen import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  arp_job_t    job_i,
  output logic        job_pop_o,
  input  logic [47:0] own_mac_i,
  input  logic        pop,
  output logic        empty,
  output logic        out_kind_o,
  output logic [31:0] peer_ip_o,
  output logic [47:0] peer_mac_o,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o
);

  logic [4:0]  pos_q, pos_d;
  logic        vld_q, vld_d;
  logic        kind_q, kind_d;
  logic [31:0] ip_q, ip_d;
  logic [47:0] mac_q, mac_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        slot_free, emit;
  logic [4:0]  q;

  assign slot_free = !vld_q || pop;
  assign emit      = job_valid_i && slot_free;
  assign q         = pos_q - 5'd1;

  always_comb begin
    pos_d     = pos_q;
    vld_d     = vld_q && !pop;
    kind_d    = kind_q;
    ip_d      = ip_q;
    mac_d     = mac_q;
    byte_d    = byte_q;
    last_d    = last_q;
    job_pop_o = 1'b0;
    if (emit) begin
      vld_d = 1'b1;
      ip_d  = job_i.sender_ip;
      if (pos_q == '0) begin
        kind_d = KindLearn;
        mac_d  = job_i.sender_mac;
        byte_d = '0;
        last_d = !job_i.answer;
        if (job_i.answer) begin
          pos_d = 5'd1;
        end else begin
          job_pop_o = 1'b1;
        end
      end else begin
        kind_d = KindReply;
        mac_d  = '0;
        byte_d = reply_byte_at(q, own_mac_i, job_i.target_ip, job_i.sender_mac,
                               job_i.sender_ip);
        last_d = (pos_q == LastPos);
        if (pos_q == LastPos) begin
          pos_d     = '0;
          job_pop_o = 1'b1;
        end else begin
          pos_d = pos_q + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ip_q   <= ip_d;
    mac_q  <= mac_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign empty        = !vld_q;
  assign out_kind_o   = kind_q;
  assign peer_ip_o    = ip_q;
  assign peer_mac_o   = mac_q;
  assign reply_byte_o = byte_q;
  assign reply_last_o = last_q;

endmodule

/* design/arp_request_responder.sv */
// top level of the arp request responder
// usage:
//   input queue: one arp payload byte per beat on in_byte_i, in_last_i on the
//   final byte; a beat is taken when push is high and full is low
//   result queue: learn beats and reply byte beats, oldest shown while empty
//   is low, taken when pop is high and empty is low
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i; the user writes only while idle, unenforced
// results: the 28th byte's job passes the job queue, then the learn beat shows;
//   a reply follows, one byte per cycle while pop is high, 29 beats in all
// throughput: one byte in per cycle while full is low, one result per cycle
//   while pop is high; the parser-to-generator job queue holds JobDepth packets
// full rises only on the 28th byte of a packet, when the job queue is full
// reset: config zero, no results or jobs pending, parser at packet start
// a stalled receiver holds the current result steady; the generator waits,
//   the job queue fills and then the 28th byte of the next packet waits
module arp_request_responder import arp_pkg::*; #(
  parameter int unsigned JobDepth = JobDepthDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind_o,
  output logic [31:0] peer_ip_o,
  output logic [47:0] peer_mac_o,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  arp_cfg_t cfg_q;
  arp_job_t job_in, job_out;
  logic     job_push, job_full, job_valid, job_pop;
  logic     stall, accept;

  assign full   = stall;
  assign accept = push && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgOwnMac: cfg_q.own_mac   <= cfg_data_i;
        CfgOwnIpA: cfg_q.own_ip[0] <= cfg_data_i[31:0];
        CfgOwnIpB: cfg_q.own_ip[1] <= cfg_data_i[31:0];
        CfgOwnIpC: cfg_q.own_ip[2] <= cfg_data_i[31:0];
        CfgOwnIpD: cfg_q.own_ip[3] <= cfg_data_i[31:0];
        CfgAddrEn: cfg_q.addr_en   <= cfg_data_i[3:0];
        default:   ;
      endcase
    end
  end

  arp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .cfg_i      (cfg_q),
    .job_full_i (job_full),
    .stall_o    (stall),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  arp_job_fifo #(.Depth(JobDepth)) u_jobs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  arp_reply_gen u_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .own_mac_i    (cfg_q.own_mac),
    .pop          (pop),
    .empty        (empty),
    .out_kind_o   (out_kind_o),
    .peer_ip_o    (peer_ip_o),
    .peer_mac_o   (peer_mac_o),
    .reply_byte_o (reply_byte_o),
    .reply_last_o (reply_last_o)
  );

endmodule

/* design/arp_checker.sv */
// port-level checks on the arp request responder, bound to the top level
module arp_checker import arp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        out_kind_o,
  input logic [31:0] peer_ip_o,
  input logic [47:0] peer_mac_o,
  input logic [7:0]  reply_byte_o,
  input logic        reply_last_o
);

  // nothing waiting straight after reset
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result pending after reset");

  // a held beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_kind_o) && $stable(peer_ip_o) &&
                          $stable(peer_mac_o) && $stable(reply_byte_o) &&
                          $stable(reply_last_o)))
    else $error("result changed while stalled");

  // a learn beat without last is followed at once by the reply
  a_reply_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && out_kind_o == KindLearn && !reply_last_o) |=>
      (!empty && out_kind_o == KindReply))
    else $error("reply did not follow learn beat");

  // unused fields are zero for each kind
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((out_kind_o == KindReply && peer_mac_o == '0) ||
                (out_kind_o == KindLearn && reply_byte_o == '0)))
    else $error("unused result field not zero");

endmodule

bind arp_request_responder arp_checker u_arp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .out_kind_o   (out_kind_o),
  .peer_ip_o    (peer_ip_o),
  .peer_mac_o   (peer_mac_o),
  .reply_byte_o (reply_byte_o),
  .reply_last_o (reply_last_o)
);
